### rtl/core/izh_pkg.sv
// Shared types, constants and Q16.16 arithmetic helpers for the Izhikevich neuron array.
package izh_pkg;

    localparam int DATA_W   = 32;
    localparam int IDX_W    = 10;
    localparam int CFG_IDX_W = 3;

    // Result queue sizing
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = 4;
    localparam int CREDIT_W   = 5;

    // Number of pipeline stages after the memory read, write-back in the last one
    localparam int PIPE_STAGES = 6;

    typedef logic signed [DATA_W-1:0] q_t;

    // Model constants in Q16.16
    localparam q_t Q_K1      = 32'sd2621;
    localparam q_t Q_K5      = 32'sd327680;
    localparam q_t Q_K140    = 32'sd9175040;
    localparam q_t Q_V_RESET = -32'sd4259840;
    localparam q_t Q_U_RESET = -32'sd851968;
    localparam q_t Q_MAX     = 32'sh7fff_ffff;
    localparam q_t Q_MIN     = 32'sh8000_0000;

    // Register reset values
    localparam q_t RST_TIME_STEP   = 32'sd6554;
    localparam q_t RST_REC_RATE    = 32'sd1311;
    localparam q_t RST_REC_SENS    = 32'sd13107;
    localparam q_t RST_RESET_V     = -32'sd4259840;
    localparam q_t RST_REC_JUMP    = 32'sd524288;
    localparam q_t RST_INPUT_CUR   = 32'sd655360;
    localparam q_t RST_THRESHOLD   = 32'sd1966080;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP    = 3'd0,
        CFG_REC_RATE     = 3'd1,
        CFG_REC_SENS     = 3'd2,
        CFG_RESET_V      = 3'd3,
        CFG_REC_JUMP     = 3'd4,
        CFG_INPUT_CUR    = 3'd5,
        CFG_THRESHOLD    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic             vld;
        logic             inr;   // index lies inside the array
        logic [IDX_W-1:0] idx;
    } stage_ctrl_t;

    typedef struct packed {
        logic [IDX_W-1:0] id;
        q_t               v;
        q_t               u;
        logic             spike;
    } result_t;

    // Exact product, floor shift by 16, saturate
    function automatic q_t qmul(input q_t a, input q_t b);
        logic signed [63:0] p;
        logic signed [47:0] q;
        p = 64'(a) * 64'(b);
        q = $signed(p[63:16]);
        if (q[47:31] != {17{q[47]}})
            return q[47] ? Q_MIN : Q_MAX;
        return $signed(q[31:0]);
    endfunction

    function automatic q_t qadd(input q_t a, input q_t b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31])
            return s[32] ? Q_MIN : Q_MAX;
        return $signed(s[31:0]);
    endfunction

    function automatic q_t qsub(input q_t a, input q_t b);
        logic signed [32:0] s;
        s = 33'(a) - 33'(b);
        if (s[32] != s[31])
            return s[32] ? Q_MIN : Q_MAX;
        return $signed(s[31:0]);
    endfunction

endpackage

### rtl/core/izhikevich_neuron_array_step_top.sv
// Izhikevich neuron array: per-neuron state memories, pipelined Euler step, result queue.
//
// Each request names a neuron; the block reads its v and u from two on-chip
// memories, runs one Euler step through a six-stage multiply pipeline and
// writes the new state back, returning v, u and a spike flag. Throughput is
// one request per cycle while in_ready is high. The pipeline never stalls:
// results land in a 16-entry queue and acceptance is credit limited, so a
// waiting result does not block new requests until sixteen results are
// outstanding in the pipeline and the queue. A request for a neuron that is
// still in flight waits (in_ready low) until the earlier update has been
// written back. Indexes at or beyond NEURON_COUNT are computed from the
// reset state and not written.
// After reset the memories are cleared to v = -65.0, u = -13.0, one entry
// per cycle; no request is accepted during the clearing pass;
// configuration writes are taken at any time.
module izhikevich_neuron_array_step_top
    import izh_pkg::*;
#(
    parameter int NEURON_COUNT = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // request channel
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [IDX_W-1:0]        neuron_index,
    // result channel
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [IDX_W-1:0]        neuron_id,
    output logic signed [DATA_W-1:0] voltage_out,
    output logic signed [DATA_W-1:0] recovery_out,
    output logic                    spiked,
    // configuration
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [DATA_W-1:0]       cfg_data
);

    localparam int AW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    q_t dt_reg, a_reg, b_reg, c_reg, d_reg, cur_reg, thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg  <= RST_TIME_STEP;
            a_reg   <= RST_REC_RATE;
            b_reg   <= RST_REC_SENS;
            c_reg   <= RST_RESET_V;
            d_reg   <= RST_REC_JUMP;
            cur_reg <= RST_INPUT_CUR;
            thr_reg <= RST_THRESHOLD;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TIME_STEP: dt_reg  <= $signed(cfg_data);
                CFG_REC_RATE:  a_reg   <= $signed(cfg_data);
                CFG_REC_SENS:  b_reg   <= $signed(cfg_data);
                CFG_RESET_V:   c_reg   <= $signed(cfg_data);
                CFG_REC_JUMP:  d_reg   <= $signed(cfg_data);
                CFG_INPUT_CUR: cur_reg <= $signed(cfg_data);
                CFG_THRESHOLD: thr_reg <= $signed(cfg_data);
                default: ;     // index past the list: ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Clearing pass after reset
    // ------------------------------------------------------------------
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == AW'(NEURON_COUNT - 1))
                clr_active_reg <= 1'b0;
            else
                clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Acceptance: credit against the result queue, same-neuron interlock
    // ------------------------------------------------------------------
    stage_ctrl_t         ctrl_reg [PIPE_STAGES];
    logic [CREDIT_W-1:0] credit_reg;
    logic                in_range;
    logic                hazard;
    logic                accept;
    logic                deliver;

    assign in_range = (32'(neuron_index) < NEURON_COUNT);

    always_comb
    begin
        hazard = 1'b0;
        for (int k = 0; k < PIPE_STAGES; k++)
        begin
            if (ctrl_reg[k].vld && ctrl_reg[k].inr && in_range
                && ctrl_reg[k].idx == neuron_index)
                hazard = 1'b1;
        end
    end

    assign in_ready = !clr_active_reg && !hazard
                      && (credit_reg < CREDIT_W'(FIFO_DEPTH));
    assign accept   = in_valid && in_ready;
    assign deliver  = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            credit_reg <= '0;
        else if (accept && !deliver)
            credit_reg <= credit_reg + 1'b1;
        else if (deliver && !accept)
            credit_reg <= credit_reg - 1'b1;
    end

    // ------------------------------------------------------------------
    // State memories
    // ------------------------------------------------------------------
    q_t v_mem [NEURON_COUNT];
    q_t u_mem [NEURON_COUNT];
    q_t v_rd_reg, u_rd_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    q_t            mem_wv, mem_wu;
    q_t            nv_fin, nu_fin;
    logic          spike_fin;

    always_comb
    begin
        if (clr_active_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wv    = Q_V_RESET;
            mem_wu    = Q_U_RESET;
        end
        else
        begin
            mem_we    = ctrl_reg[PIPE_STAGES-1].vld && ctrl_reg[PIPE_STAGES-1].inr;
            mem_waddr = AW'(ctrl_reg[PIPE_STAGES-1].idx);
            mem_wv    = nv_fin;
            mem_wu    = nu_fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            v_mem[mem_waddr] <= mem_wv;
            u_mem[mem_waddr] <= mem_wu;
        end
        if (accept)
        begin
            v_rd_reg <= v_mem[AW'(neuron_index)];
            u_rd_reg <= u_mem[AW'(neuron_index)];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_STAGES; k++)
                ctrl_reg[k] <= '0;
        end
        else
        begin
            ctrl_reg[0] <= '{vld: accept, inr: in_range, idx: neuron_index};
            for (int k = 1; k < PIPE_STAGES; k++)
                ctrl_reg[k] <= ctrl_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    // stage 0: out-of-range neurons start from the reset state
    q_t v0, u0;
    assign v0 = ctrl_reg[0].inr ? v_rd_reg : Q_V_RESET;
    assign u0 = ctrl_reg[0].inr ? u_rd_reg : Q_U_RESET;

    q_t s1_v_reg, s1_u_reg, s1_m1_reg, s1_m2_reg, s1_m3_reg;
    q_t s2_v_reg, s2_u_reg, s2_sq_reg, s2_m2_reg, s2_t_reg;
    q_t s3_v_reg, s3_u_reg, s3_sa_reg, s3_r_reg;
    q_t s4_v_reg, s4_u_reg, s4_sb_reg, s4_du_reg;
    q_t s5_v_reg, s5_dv_reg, s5_nu_reg;

    always_ff @(posedge clk)
    begin
        // 0.04v, 5v, bv
        s1_v_reg  <= v0;
        s1_u_reg  <= u0;
        s1_m1_reg <= qmul(Q_K1, v0);
        s1_m2_reg <= qmul(Q_K5, v0);
        s1_m3_reg <= qmul(b_reg, v0);
        // 0.04v^2, bv - u
        s2_v_reg  <= s1_v_reg;
        s2_u_reg  <= s1_u_reg;
        s2_sq_reg <= qmul(s1_m1_reg, s1_v_reg);
        s2_m2_reg <= s1_m2_reg;
        s2_t_reg  <= qsub(s1_m3_reg, s1_u_reg);
        // partial sum, a(bv - u)
        s3_v_reg  <= s2_v_reg;
        s3_u_reg  <= s2_u_reg;
        s3_sa_reg <= qadd(qadd(s2_sq_reg, s2_m2_reg), Q_K140);
        s3_r_reg  <= qmul(a_reg, s2_t_reg);
        // full bracket, du
        s4_v_reg  <= s3_v_reg;
        s4_u_reg  <= s3_u_reg;
        s4_sb_reg <= qadd(qsub(s3_sa_reg, s3_u_reg), cur_reg);
        s4_du_reg <= qmul(s3_r_reg, dt_reg);
        // dv, u + du
        s5_v_reg  <= s4_v_reg;
        s5_dv_reg <= qmul(s4_sb_reg, dt_reg);
        s5_nu_reg <= qadd(s4_u_reg, s4_du_reg);
    end

    // stage 5: new v, spike test and reset; written back and queued here
    q_t nv_raw;
    assign nv_raw    = qadd(s5_v_reg, s5_dv_reg);
    assign spike_fin = (nv_raw > thr_reg);
    assign nv_fin    = spike_fin ? c_reg : nv_raw;
    assign nu_fin    = spike_fin ? qadd(s5_nu_reg, d_reg) : s5_nu_reg;

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    result_t          fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW:0] wr_ptr_reg, rd_ptr_reg;
    logic             push;
    result_t          head;

    assign push = ctrl_reg[PIPE_STAGES-1].vld;

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg[FIFO_AW-1:0]] <= '{id: ctrl_reg[PIPE_STAGES-1].idx,
                                                   v: nv_fin, u: nu_fin,
                                                   spike: spike_fin};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (deliver)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    assign head         = fifo_mem[rd_ptr_reg[FIFO_AW-1:0]];
    assign out_valid    = (wr_ptr_reg != rd_ptr_reg);
    assign neuron_id    = head.id;
    assign voltage_out  = head.v;
    assign recovery_out = head.u;
    assign spiked       = head.spike;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic             stage_dup;
    logic [FIFO_AW:0] fifo_fill;

    assign fifo_fill = wr_ptr_reg - rd_ptr_reg;

    always_comb
    begin
        stage_dup = 1'b0;
        for (int i = 0; i < PIPE_STAGES; i++)
            for (int j = i + 1; j < PIPE_STAGES; j++)
                if (ctrl_reg[i].vld && ctrl_reg[i].inr && ctrl_reg[j].vld
                    && ctrl_reg[j].inr && ctrl_reg[i].idx == ctrl_reg[j].idx)
                    stage_dup = 1'b1;
    end

    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clr_active_reg |-> !in_ready)
        else $error("request accepted during clearing pass");

    a_pipe_empty_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clr_active_reg |-> !push)
        else $error("write-back collides with clearing pass");

    a_no_same_neuron_in_flight: assert property (
        @(posedge clk) disable iff (!rst_n) !stage_dup)
        else $error("two updates of one neuron in flight");

    a_credit_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        credit_reg <= CREDIT_W'(FIFO_DEPTH) && CREDIT_W'(fifo_fill) <= credit_reg)
        else $error("result queue credit out of step");

endmodule
